FILE: design/pafk_pkg.sv
// ============================================================================
// pafk_pkg
// Shared types, constants and tables for the planar arm forward kinematics
// block: the command item between the front and back parts, the CORDIC
// arctangent table and the register map.
// ============================================================================
`default_nettype none

package pafk_pkg;

    // Default parameter values
    localparam int DEF_MAX_LINKS    = 6;
    localparam int DEF_CORDIC_STEPS = 16;
    localparam int QUEUE_DEPTH      = 2;

    // Field widths
    localparam int ANGLE_W  = 16;
    localparam int LENGTH_W = 16;
    localparam int JOINT_W  = 3;
    localparam int POS_W    = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // CORDIC datapath widths
    localparam int CX_W      = 35;  // x, y: length * 1/K in Q16 plus growth
    localparam int CZ_W      = 26;  // angle scaled so that 2^23 = pi
    localparam int ATAN_IDX_W = 5;
    localparam int ROUND_SHIFT = 16;

    // 1/K in Q16
    localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_LINK_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_LENGTH_0 = 3'd1;

    localparam logic [2:0]          LINK_COUNT_RESET = 3'd2;
    localparam logic [LENGTH_W-1:0] LENGTH_ONE       = 16'd256;

    // Command item from front to back
    typedef struct packed {
        logic                       start;
        logic                       oor;
        logic                       neg;    // start vector negated (angle folded by pi)
        logic signed [ANGLE_W-1:0]  angle;  // folded to [-pi/2, pi/2)
        logic [LENGTH_W-1:0]        length;
        logic [JOINT_W-1:0]         joint;
        logic                       last;
    } cmd_t;

    // Reset value of link length k
    function automatic logic [LENGTH_W-1:0] length_reset(input int k);
        return (k < 2) ? LENGTH_ONE : '0;
    endfunction

    // atan(2^-i) * 2^23 / pi, rounded
    function automatic logic signed [CZ_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] i);
        logic signed [CZ_W-1:0] v;
        case (i)
            5'd0:  v = 26'sd2097152;
            5'd1:  v = 26'sd1238021;
            5'd2:  v = 26'sd654136;
            5'd3:  v = 26'sd332050;
            5'd4:  v = 26'sd166669;
            5'd5:  v = 26'sd83416;
            5'd6:  v = 26'sd41718;
            5'd7:  v = 26'sd20860;
            5'd8:  v = 26'sd10430;
            5'd9:  v = 26'sd5215;
            5'd10: v = 26'sd2608;
            5'd11: v = 26'sd1304;
            5'd12: v = 26'sd652;
            5'd13: v = 26'sd326;
            5'd14: v = 26'sd163;
            5'd15: v = 26'sd81;
            5'd16: v = 26'sd41;
            5'd17: v = 26'sd20;
            5'd18: v = 26'sd10;
            5'd19: v = 26'sd5;
            5'd20: v = 26'sd3;
            5'd21: v = 26'sd1;
            5'd22: v = 26'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: design/planar_arm_forward_kinematics_top.sv
// ============================================================================
// planar_arm_forward_kinematics_top
// Forward kinematics of a planar serial arm, one joint position per item.
// ============================================================================
// Usage:
//   Input stream: s_tdata carries the relative joint angle (binary angle,
//   32768 = pi), s_tuser is the start flag that restarts the chain at the
//   base. Each item yields one result on the output stream: joint number and
//   saturated Q11.8 x, y position in m_tdata, m_tlast on the end effector,
//   m_tuser set for an item past the configured link count (data zero).
//   Configuration: cfg_wen / cfg_index / cfg_wdata write link_count (index 0)
//   and the link lengths (index 1..6); write only while the block is idle.
//   Sequence: an in-range item passes the back part as a load step with
//   the gain multiply, CORDIC_STEPS iterations of the shared CORDIC unit
//   and an accumulate/output step; out-of-range items skip the iterations.
//   The back part takes a new item only after it is through with the last.
//   A two-entry command queue lets items be accepted while the CORDIC works.
//   Reset: chain state and position sums clear, registers take their reset
//   values. A stalled receiver holds the output register; the queue then
//   fills and s_tready drops.
`default_nettype none

module planar_arm_forward_kinematics_top #(
    parameter int MAX_LINKS    = pafk_pkg::DEF_MAX_LINKS,
    parameter int CORDIC_STEPS = pafk_pkg::DEF_CORDIC_STEPS
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    // configuration write port
    input  wire                                 cfg_wen,
    input  wire [pafk_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire [pafk_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // input stream
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire [15:0]                          s_tdata,   // [15:0] joint_angle
    input  wire [0:0]                           s_tuser,   // [0] start_req
    // result stream
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [47:0]                         m_tdata,   // [2:0] joint_number,
                                                           // [22:3] pos_x, [42:23] pos_y
    output logic                                m_tlast,   // last
    output logic [0:0]                          m_tuser    // [0] out_of_range
);

    pafk_pkg::cmd_t  f_cmd, q_cmd;
    logic            f_valid, f_ready, q_valid, q_ready;
    logic [pafk_pkg::JOINT_W-1:0]       joint;
    logic signed [pafk_pkg::POS_W-1:0]  pos_x, pos_y;
    logic            oor;

    pafk_front #(
        .MAX_LINKS (MAX_LINKS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_angle  (s_tdata),
        .in_start  (s_tuser[0]),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd       (f_cmd)
    );

    pafk_queue #(
        .DEPTH (pafk_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_cmd   (f_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    pafk_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_joint (joint),
        .out_x     (pos_x),
        .out_y     (pos_y),
        .out_last  (m_tlast),
        .out_oor   (oor)
    );

    assign m_tdata    = {5'b00000, pos_y, pos_x, joint};
    assign m_tuser[0] = oor;

    // Out-of-range items carry no position and never close a chain
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tlast)
        else $error("out-of-range result with nonzero data or last");

    // In-range items name a joint between 1 and MAX_LINKS
    a_joint_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |->
            m_tdata[2:0] != '0 && m_tdata[2:0] <= pafk_pkg::JOINT_W'(MAX_LINKS))
        else $error("joint number out of range on in-range result");

    // Nothing is presented in the cycle after reset
    a_reset_quiet: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

FILE: design/pafk_queue.sv
// ============================================================================
// pafk_queue
// Short FIFO of command items between the front and back parts, so each
// side stalls on its own.
// ============================================================================
`default_nettype none

module pafk_queue #(
    parameter int DEPTH = pafk_pkg::QUEUE_DEPTH
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push_valid,
    output logic                push_ready,
    input  pafk_pkg::cmd_t      push_cmd,
    output logic                pop_valid,
    input  wire                 pop_ready,
    output pafk_pkg::cmd_t      pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pafk_pkg::cmd_t     mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid & push_ready;
    assign pop        = pop_valid & pop_ready;
    assign pop_cmd    = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/pafk_front.sv
// ============================================================================
// pafk_front
// Front part: holds the configuration registers and the chain state (link
// counter, absolute angle), accepts joint angle items and turns each one
// into a command for the CORDIC back part.
// ============================================================================
`default_nettype none

module pafk_front #(
    parameter int MAX_LINKS = pafk_pkg::DEF_MAX_LINKS
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    // configuration
    input  wire                                 cfg_wen,
    input  wire [pafk_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire [pafk_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    // input items
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire signed [pafk_pkg::ANGLE_W-1:0]  in_angle,
    input  wire                                 in_start,
    // commands out
    output logic                                cmd_valid,
    input  wire                                 cmd_ready,
    output pafk_pkg::cmd_t                      cmd
);

    localparam int IDX_W = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
    localparam int JW    = pafk_pkg::JOINT_W;
    localparam int AW    = pafk_pkg::ANGLE_W;

    logic [2:0]                       link_count_reg;
    logic [pafk_pkg::LENGTH_W-1:0]    length_reg [MAX_LINKS];
    logic [JW-1:0]                    link_counter_reg;
    logic [AW-1:0]                    abs_angle_reg;

    logic [JW-1:0]  count_eff;
    logic [JW-1:0]  counter_cur;
    logic [JW-1:0]  joint_next;
    logic [AW-1:0]  abs_cur;
    logic [AW-1:0]  abs_next;
    logic           oor;
    logic           fold;
    logic           accept;

    // Link count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_count_reg <= pafk_pkg::LINK_COUNT_RESET;
        end else if (cfg_wen && cfg_index == pafk_pkg::REG_LINK_COUNT) begin
            link_count_reg <= cfg_wdata[2:0];
        end
    end

    // Link length registers; lengths past MAX_LINKS are never used
    for (genvar k = 0; k < MAX_LINKS; k++) begin : g_len
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                length_reg[k] <= pafk_pkg::length_reset(k);
            end else if (cfg_wen &&
                         cfg_index == pafk_pkg::REG_LINK_LENGTH_0 + pafk_pkg::CFG_IDX_W'(k)) begin
                length_reg[k] <= cfg_wdata[pafk_pkg::LENGTH_W-1:0];
            end
        end
    end

    // Classify the item
    always_comb begin
        count_eff   = (link_count_reg > JW'(MAX_LINKS)) ? JW'(MAX_LINKS) : link_count_reg;
        counter_cur = in_start ? '0 : link_counter_reg;
        abs_cur     = in_start ? '0 : abs_angle_reg;
        oor         = (counter_cur >= count_eff);
        joint_next  = counter_cur + 1'b1;
        abs_next    = abs_cur + in_angle;
        // Fold into [-pi/2, pi/2): adding pi flips the sign bit
        fold        = (abs_next[AW-1] != abs_next[AW-2]);

        cmd.start  = in_start;
        cmd.oor    = oor;
        cmd.neg    = fold;
        cmd.angle  = {abs_next[AW-1] ^ fold, abs_next[AW-2:0]};
        cmd.length = length_reg[counter_cur[IDX_W-1:0]];
        cmd.joint  = joint_next;
        cmd.last   = (joint_next == count_eff);
    end

    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;
    assign accept    = in_valid & cmd_ready;

    // Chain state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_counter_reg <= '0;
            abs_angle_reg    <= '0;
        end else if (accept) begin
            if (!oor) begin
                link_counter_reg <= joint_next;
                abs_angle_reg    <= abs_next;
            end else if (in_start) begin
                link_counter_reg <= '0;
                abs_angle_reg    <= '0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/pafk_back.sv
// ============================================================================
// pafk_back
// Back part: iterative rotation-mode CORDIC, one step per cycle, that turns
// a link length and angle into a vector, then accumulates the saturated
// joint position and holds it in the output register; out-of-range items skip the CORDIC.
// ============================================================================
`default_nettype none

module pafk_back #(
    parameter int CORDIC_STEPS = pafk_pkg::DEF_CORDIC_STEPS
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  cmd_valid,
    output logic                                 cmd_ready,
    input  pafk_pkg::cmd_t                       cmd,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic [pafk_pkg::JOINT_W-1:0]         out_joint,
    output logic signed [pafk_pkg::POS_W-1:0]    out_x,
    output logic signed [pafk_pkg::POS_W-1:0]    out_y,
    output logic                                 out_last,
    output logic                                 out_oor
);

    localparam int CX    = pafk_pkg::CX_W;
    localparam int CZ    = pafk_pkg::CZ_W;
    localparam int PW    = pafk_pkg::POS_W;
    localparam int RS    = pafk_pkg::ROUND_SHIFT;
    localparam int RW    = CX - RS;
    localparam int ITER_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    typedef enum logic [1:0] {ST_IDLE, ST_ITER, ST_DONE} state_t;

    state_t                 state_reg;
    pafk_pkg::cmd_t         cmd_reg;
    logic signed [CX-1:0]   x_reg, y_reg;
    logic signed [CZ-1:0]   z_reg;
    logic [ITER_W-1:0]      iter_reg;
    logic signed [PW-1:0]   sum_x_reg, sum_y_reg;

    logic [31:0]            prod;
    logic signed [CX-1:0]   x0;
    logic signed [CX-1:0]   dx, dy, x_rnd, y_rnd;
    logic signed [CZ-1:0]   atan_i;
    logic signed [RW-1:0]   rx, ry;
    logic signed [PW-1:0]   base_x, base_y, sat_x, sat_y;
    logic signed [PW:0]     wide_x, wide_y;
    logic                   out_free;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign out_free  = !out_valid || out_ready;

    // Start vector, CORDIC step terms and final accumulation
    always_comb begin
        prod   = cmd.length * pafk_pkg::INV_GAIN_Q16;
        x0     = cmd.neg ? -signed'({3'b000, prod}) : signed'({3'b000, prod});
        dx     = y_reg >>> iter_reg;
        dy     = x_reg >>> iter_reg;
        atan_i = pafk_pkg::atan_entry(pafk_pkg::ATAN_IDX_W'(iter_reg));

        x_rnd  = x_reg + CX'(32768);
        y_rnd  = y_reg + CX'(32768);
        rx     = x_rnd[CX-1:RS];
        ry     = y_rnd[CX-1:RS];
        base_x = cmd_reg.start ? '0 : sum_x_reg;
        base_y = cmd_reg.start ? '0 : sum_y_reg;
        wide_x = {base_x[PW-1], base_x} + (PW+1)'(rx);
        wide_y = {base_y[PW-1], base_y} + (PW+1)'(ry);
        // Saturate on signed overflow
        if (wide_x[PW] != wide_x[PW-1]) begin
            sat_x = {wide_x[PW], {(PW-1){~wide_x[PW]}}};
        end else begin
            sat_x = wide_x[PW-1:0];
        end
        if (wide_y[PW] != wide_y[PW-1]) begin
            sat_y = {wide_y[PW], {(PW-1){~wide_y[PW]}}};
        end else begin
            sat_y = wide_y[PW-1:0];
        end
    end

    // Sequencer, CORDIC registers, position sums and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_valid <= 1'b0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
        end else begin
            // In ST_DONE the output register is reloaded below instead
            if (out_valid && out_ready && state_reg != ST_DONE) begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (cmd_valid) begin
                        cmd_reg  <= cmd;
                        x_reg    <= x0;
                        y_reg    <= '0;
                        // angle in the top bits, sign carried into the guard bits
                        z_reg    <= CZ'(signed'({cmd.angle, 8'h00}));
                        iter_reg <= '0;
                        state_reg <= cmd.oor ? ST_DONE : ST_ITER;
                    end
                end
                ST_ITER: begin
                    if (!z_reg[CZ-1]) begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - atan_i;
                    end else begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + atan_i;
                    end
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == ITER_W'(CORDIC_STEPS - 1)) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        out_valid <= 1'b1;
                        if (cmd_reg.oor) begin
                            out_joint <= '0;
                            out_x     <= '0;
                            out_y     <= '0;
                            out_last  <= 1'b0;
                            out_oor   <= 1'b1;
                            if (cmd_reg.start) begin
                                sum_x_reg <= '0;
                                sum_y_reg <= '0;
                            end
                        end else begin
                            out_joint <= cmd_reg.joint;
                            out_x     <= sat_x;
                            out_y     <= sat_y;
                            out_last  <= cmd_reg.last;
                            out_oor   <= 1'b0;
                            sum_x_reg <= sat_x;
                            sum_y_reg <= sat_y;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the planar arm forward kinematics block. Relative
// joint angles are streamed in and each joint position is checked against a
// fixed-point CORDIC predictor kept in step with the block. Directed items
// cover the reset defaults, the angle folds, out-of-range links, count
// saturation and a count change in the middle of a chain. Random poses
// follow, with random link settings and random idling on both streams.
// ============================================================================

module testbench;

    localparam int     CORDIC_ITERS    = 16;
    localparam int     ARM_MAX_LINKS   = 6;
    localparam longint ROTATE_GAIN_Q16 = 39797;     // 1/K in Q16
    localparam int     STALL_LIMIT     = 5000;
    localparam int     DRAIN_CYCLES    = 40;
    localparam int     PHASES          = 12;
    localparam int     PHASE_ITEMS     = 158;

    // Index just past the register map, writes there are ignored
    localparam logic [pafk_pkg::CFG_IDX_W-1:0] REG_OUTSIDE_MAP = 3'd7;

    // One joint position as it leaves the block
    typedef struct packed {
        logic [pafk_pkg::JOINT_W-1:0]       joint;
        logic signed [pafk_pkg::POS_W-1:0]  pos_x;
        logic signed [pafk_pkg::POS_W-1:0]  pos_y;
        logic                               last;
        logic                               oor;
    } joint_pos_t;

    // atan(2^-i) scaled so that 2^23 = pi
    longint atan_q23 [CORDIC_ITERS] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81
    };

    // DUT signals
    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wen   = 1'b0;
    logic [pafk_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pafk_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    wire                             s_tready;
    logic [15:0]                     s_tdata   = '0;  // [15:0] joint_angle
    logic [0:0]                      s_tuser   = '0;  // [0] start_req
    wire                             m_tvalid;
    logic                            m_tready  = 1'b0;
    wire  [47:0]                     m_tdata;         // [2:0] joint_number, [22:3] pos_x,
                                                      // [42:23] pos_y
    wire                             m_tlast;
    wire  [0:0]                      m_tuser;         // [0] out_of_range

    // Predictor state and settings
    logic [2:0]                      arm_link_count;
    logic [pafk_pkg::LENGTH_W-1:0]   arm_length [ARM_MAX_LINKS];
    int                              chain_idx;
    logic [pafk_pkg::ANGLE_W-1:0]    abs_angle;
    int                              sum_x;
    int                              sum_y;
    joint_pos_t                      joint_pos_q [$];

    // Bench bookkeeping
    int                    mismatch_count = 0;
    int                    items_sent     = 0;
    int                    quiet_cycles   = 0;
    int                    rx_hold        = 0;
    logic                  tx_idle        = 1'b0;
    logic                  rx_idle        = 1'b0;
    joint_pos_t            want;

    planar_arm_forward_kinematics_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic void init_model();
        int k;
        arm_link_count = pafk_pkg::LINK_COUNT_RESET;
        for (k = 0; k < ARM_MAX_LINKS; k++)
            arm_length[k] = (k < 2) ? 16'd256 : 16'd0;
        chain_idx = 0;
        abs_angle = '0;
        sum_x     = 0;
        sum_y     = 0;
    endfunction

    // Counts above the hardware maximum saturate
    function automatic int links_in_use();
        return (arm_link_count > ARM_MAX_LINKS) ? ARM_MAX_LINKS : int'(arm_link_count);
    endfunction

    function automatic int clamp_q11_8(input longint v);
        if (v > 524287)
            return 524287;
        if (v < -524288)
            return -524288;
        return int'(v);
    endfunction

    // Rotate (len, 0) by a binary angle; result rounded to Q8.8
    function automatic void cordic_rotate_q8(input logic [pafk_pkg::LENGTH_W-1:0] len,
                                             input logic signed [pafk_pkg::ANGLE_W-1:0] ang,
                                             output longint rx, output longint ry);
        longint x, y, z, dx, dy;
        int     a;
        int     i;
        x = longint'(len) * ROTATE_GAIN_Q16;
        y = 0;
        a = ang;
        // fold into [-pi/2, pi/2) by flipping the start vector
        if (a >= 16384) begin
            x = -x;
            a -= 32768;
        end else if (a < -16384) begin
            x = -x;
            a += 32768;
        end
        z = longint'(a) * 256;
        for (i = 0; i < CORDIC_ITERS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= atan_q23[i];
            end else begin
                x += dx;
                y -= dy;
                z += atan_q23[i];
            end
        end
        rx = (x + 32768) >>> 16;
        ry = (y + 32768) >>> 16;
    endfunction

    // Advance the chain by one accepted angle and queue the joint position
    function automatic void predict_joint(input logic [pafk_pkg::ANGLE_W-1:0] ang,
                                          input logic start);
        joint_pos_t res;
        longint     rx, ry;
        int         n;
        n   = links_in_use();
        res = '0;
        if (start) begin
            chain_idx = 0;
            abs_angle = '0;
            sum_x     = 0;
            sum_y     = 0;
        end
        if (chain_idx >= n) begin
            res.oor = 1'b1;
        end else begin
            abs_angle = abs_angle + ang;
            cordic_rotate_q8(arm_length[chain_idx], abs_angle, rx, ry);
            sum_x = clamp_q11_8(longint'(sum_x) + rx);
            sum_y = clamp_q11_8(longint'(sum_y) + ry);
            chain_idx++;
            res.joint = 3'(chain_idx);
            res.pos_x = sum_x[pafk_pkg::POS_W-1:0];
            res.pos_y = sum_y[pafk_pkg::POS_W-1:0];
            res.last  = (chain_idx == n);
        end
        joint_pos_q.insert(joint_pos_q.size(), res);
    endfunction

    // ------------------------------------------------------------------------
    // Result side: ready with random holds, and the checker
    // ------------------------------------------------------------------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            rx_hold = 0;
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                rx_hold = rx_idle ? $urandom_range(0, 5) : 0;
            else if (rx_hold > 0)
                rx_hold--;
            else if (rx_idle && $urandom_range(0, 15) == 0)
                rx_hold = $urandom_range(1, 5);
            m_tready <= (rx_hold == 0);
        end
    end

    function automatic void flag_mismatch(input string what, input longint exp_v,
                                          input longint got_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %s: expected %0d, got %0d", what, exp_v, got_v);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (joint_pos_q.size() == 0) begin
                flag_mismatch("result with nothing pending (tdata)", 0, longint'(m_tdata));
            end else begin
                want = joint_pos_q.pop_front();
                if (m_tdata[2:0] !== want.joint)
                    flag_mismatch("joint_number", want.joint, m_tdata[2:0]);
                if (m_tdata[22:3] !== want.pos_x)
                    flag_mismatch("pos_x", $signed(want.pos_x), $signed(m_tdata[22:3]));
                if (m_tdata[42:23] !== want.pos_y)
                    flag_mismatch("pos_y", $signed(want.pos_y), $signed(m_tdata[42:23]));
                if (m_tdata[47:43] !== 5'd0)
                    flag_mismatch("tdata padding", 0, m_tdata[47:43]);
                if (m_tlast !== want.last)
                    flag_mismatch("last", want.last, m_tlast);
                if (m_tuser[0] !== want.oor)
                    flag_mismatch("out_of_range", want.oor, m_tuser[0]);
            end
        end
    end

    // Watchdog on handshake activity
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Send one angle item; the expectation is queued at the accepting edge
    task automatic send_joint(input logic [pafk_pkg::ANGLE_W-1:0] ang, input logic start);
        int gap;
        gap = tx_idle ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= ang;
        s_tuser[0] <= start;
        do @(posedge aclk); while (!s_tready);
        predict_joint(ang, start);
        items_sent++;
    endtask

    // Hold off the input until every queued position has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (joint_pos_q.size() != 0);
    endtask

    task automatic write_reg(input logic [pafk_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pafk_pkg::CFG_DATA_W-1:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        if (idx == pafk_pkg::REG_LINK_COUNT)
            arm_link_count = val[2:0];
        else if (idx >= pafk_pkg::REG_LINK_LENGTH_0 &&
                 idx < pafk_pkg::REG_LINK_LENGTH_0 + ARM_MAX_LINKS)
            arm_length[idx - pafk_pkg::REG_LINK_LENGTH_0] = val;
        @(posedge aclk);
    endtask

    function automatic logic [pafk_pkg::ANGLE_W-1:0] pick_angle();
        case ($urandom_range(0, 11))
            0:       return 16'h8000;  // -pi
            1:       return 16'h7FFF;
            2:       return 16'h4000;  // +pi/2, folds
            3:       return 16'hC000;  // -pi/2, no fold
            4:       return 16'hBFFF;  // just below -pi/2, folds
            5:       return 16'h3FFF;
            6:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic randomize_arm();
        int                              k;
        int                              cnt;
        logic [pafk_pkg::LENGTH_W-1:0]   len;
        if ($urandom_range(0, 7) == 0)
            cnt = $urandom_range(0, 1) ? 7 : 0;
        else
            cnt = $urandom_range(1, 6);
        write_reg(pafk_pkg::REG_LINK_COUNT, pafk_pkg::CFG_DATA_W'(cnt));
        for (k = 0; k < ARM_MAX_LINKS; k++) begin
            case ($urandom_range(0, 5))
                0:       len = 16'h0000;
                1:       len = 16'hFFFF;
                2, 3:    len = 16'($urandom_range(0, 1023));
                default: len = 16'($urandom);
            endcase
            write_reg(pafk_pkg::CFG_IDX_W'(pafk_pkg::REG_LINK_LENGTH_0 + k), len);
        end
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_OUTSIDE_MAP, 16'($urandom));
    endtask

    // Mostly whole poses; some overruns, broken restarts and loose items
    task automatic send_random_chain();
        int kind;
        int n;
        int i;
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
            n = links_in_use();
            if ($urandom_range(0, 3) == 0)
                n += $urandom_range(1, 2);
            if (n == 0)
                n = $urandom_range(1, 2);
            for (i = 0; i < n; i++)
                send_joint(pick_angle(), i == 0);
        end else if (kind == 7) begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++)
                send_joint(pick_angle(), $urandom_range(0, 3) == 0);
        end else if (kind == 8) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
                send_joint(pick_angle(), i == 0);
        end else begin
            send_joint(16'($urandom), 1'($urandom_range(0, 1)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Two unit links after reset, folds at the quadrant edges, one overrun
    task automatic test_reset_values();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_joint(16'h0000, 1'b1);
        send_joint(16'h4000, 1'b0);
        send_joint(16'h1234, 1'b0);
        send_joint(16'h8000, 1'b1);
        send_joint(16'h7FFF, 1'b0);
        send_joint(16'hC000, 1'b1);
        send_joint(16'hBFFF, 1'b0);
        send_joint(16'h3FFF, 1'b1);
        send_joint(16'hFFFF, 1'b0);
    endtask

    // Count zero, count saturating at six with longest links, zero length
    task automatic test_register_extremes();
        int k;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        drain_results();
        write_reg(pafk_pkg::REG_LINK_COUNT, 16'd0);
        for (k = 0; k < ARM_MAX_LINKS; k++)
            write_reg(pafk_pkg::CFG_IDX_W'(pafk_pkg::REG_LINK_LENGTH_0 + k), 16'hFFFF);
        write_reg(REG_OUTSIDE_MAP, 16'hFFFF);
        send_joint(16'h5555, 1'b1);
        send_joint(16'hAAAA, 1'b0);
        drain_results();
        write_reg(pafk_pkg::REG_LINK_COUNT, 16'd7);
        send_joint(16'h8000, 1'b1);
        send_joint(16'h7FFF, 1'b0);
        send_joint(16'h4000, 1'b0);
        send_joint(16'hC000, 1'b0);
        send_joint(16'hBFFF, 1'b0);
        send_joint(16'h0001, 1'b0);
        send_joint(16'hFFFF, 1'b0);
        drain_results();
        write_reg(pafk_pkg::REG_LINK_COUNT, 16'd1);
        write_reg(pafk_pkg::REG_LINK_LENGTH_0, 16'h0000);
        send_joint(16'h2000, 1'b1);
        send_joint(16'h0000, 1'b0);
    endtask

    // Lower the count below the links done, then raise it and resume
    task automatic test_mid_chain_config();
        int k;
        drain_results();
        write_reg(pafk_pkg::REG_LINK_COUNT, 16'd6);
        for (k = 0; k < ARM_MAX_LINKS; k++)
            write_reg(pafk_pkg::CFG_IDX_W'(pafk_pkg::REG_LINK_LENGTH_0 + k),
                      pafk_pkg::CFG_DATA_W'(256 * (k + 1)));
        send_joint(16'h1000, 1'b1);
        send_joint(16'h2000, 1'b0);
        send_joint(16'hE000, 1'b0);
        drain_results();
        write_reg(pafk_pkg::REG_LINK_COUNT, 16'd2);
        send_joint(16'h0100, 1'b0);
        send_joint(16'h0200, 1'b0);
        drain_results();
        write_reg(pafk_pkg::REG_LINK_COUNT, 16'd6);
        send_joint(16'h0300, 1'b0);
        send_joint(16'h9000, 1'b0);
        send_joint(16'h6000, 1'b0);
    endtask

    // Random link settings per phase; every phase starts from an empty pipe
    task automatic test_random_poses();
        int phase;
        int phase_start;
        for (phase = 0; phase < PHASES; phase++) begin
            drain_results();
            randomize_arm();
            tx_idle = (phase % 4 != 0) && ($urandom_range(0, 3) != 0);
            rx_idle = (phase % 4 != 0) && ($urandom_range(0, 3) != 0);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_random_chain();
        end
    endtask

    initial begin
        init_model();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_values();
        test_register_extremes();
        test_mid_chain_config();
        test_random_poses();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && joint_pos_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: planar_arm_forward_kinematics_top.f
design/pafk_pkg.sv
design/pafk_queue.sv
design/pafk_front.sv
design/pafk_back.sv
design/planar_arm_forward_kinematics_top.sv
sim/testbench.sv
